@@ design/tach_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tach_pkg: shared types and constants of the averaging tachometer
// Register indexes, field widths and the word passed from front to back.
// ----------------------------------------------------------------------------
package tach_pkg;

	// configuration register widths and indexes
	localparam int RATE_W   = 27;
	localparam int PPR_W    = 13;
	localparam int EPA_W    = 9;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W    = 27;

	localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PPR       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EPA       = 2'd2;

	localparam logic [RATE_W-1:0] TICK_RATE_RST = 27'd16000000;
	localparam logic [PPR_W-1:0]  PPR_RST       = 13'd144;
	localparam logic [EPA_W-1:0]  EPA_RST       = 9'd200;

	// result widths
	localparam int SUM_W = 40;
	localparam int RPM_W = 32;
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic [RPM_W-1:0] RPM_MAX = {RPM_W{1'b1}};

	// 60 s per minute times 100 hundredths
	localparam int SCALE_W   = 13;
	localparam logic [SCALE_W-1:0] RPM_SCALE = 13'd6000;

	// datapath widths of the speed calculation
	localparam int R6_W  = SCALE_W + RATE_W;   // 6000 * tick rate
	localparam int NUM_W = R6_W + EPA_W;       // times edge count
	localparam int DEN_W = PPR_W + SUM_W;      // pulses times sum
	localparam int DIV_CNT_W = $clog2(NUM_W);

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// one finished average waiting for the speed calculation
	typedef struct packed {
		logic [EPA_W-1:0] edges;
		logic [SUM_W-1:0] sum;
	} tach_job_t;

	// queue handshake towards the back
	typedef struct packed {
		logic     valid;
		tach_job_t job;
	} tach_qout_t;

endpackage

@@ design/tach_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tach_front: tick counting and period accumulation
// Counts ticks between encoder edges, sums the periods and hands a job to
// the queue once the configured number of edges has been seen.
// ----------------------------------------------------------------------------
module tach_front #(
	parameter int MAX_EDGES   = 256,
	parameter int PERIOD_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      tick,
	input  logic                      capture_edge,
	input  logic [tach_pkg::EPA_W-1:0] edges_per_average,
	output logic                      job_push,
	output tach_pkg::tach_job_t       job
);
	import tach_pkg::*;

	localparam int ADD_W = ((PERIOD_BITS > SUM_W) ? PERIOD_BITS : SUM_W) + 1;
	localparam logic [PERIOD_BITS-1:0] CNT_MAX = {PERIOD_BITS{1'b1}};

	logic [PERIOD_BITS-1:0] tick_cnt_q;
	logic [SUM_W-1:0]       sum_q;
	logic [EPA_W-1:0]       edge_cnt_q;

	logic [PERIOD_BITS-1:0] period;
	logic [ADD_W-1:0]       sum_ext;
	logic [SUM_W-1:0]       sum_new;
	logic [EPA_W-1:0]       edge_new;
	logic [EPA_W-1:0]       n_eff;
	logic                   done;

	// effective number of edges per average
	always_comb begin
		if (edges_per_average == '0) begin
			n_eff = EPA_W'(1);
		end else if (32'(edges_per_average) > MAX_EDGES) begin
			n_eff = EPA_W'(MAX_EDGES);
		end else begin
			n_eff = edges_per_average;
		end
	end

	// saturating period and sum
	assign period   = (tick_cnt_q == CNT_MAX) ? tick_cnt_q : tick_cnt_q + 1'b1;
	assign sum_ext  = ADD_W'(sum_q) + ADD_W'(period);
	assign sum_new  = (sum_ext > ADD_W'(SUM_MAX)) ? SUM_MAX : sum_ext[SUM_W-1:0];
	assign edge_new = edge_cnt_q + 1'b1;
	assign done     = edge_new >= n_eff;

	assign job_push  = tick && capture_edge && done;
	assign job.edges = n_eff;
	assign job.sum   = sum_new;

	// counter, sum and edge count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_cnt_q <= '0;
			sum_q      <= '0;
			edge_cnt_q <= '0;
		end else if (tick) begin
			if (capture_edge) begin
				tick_cnt_q <= '0;
				if (done) begin
					sum_q      <= '0;
					edge_cnt_q <= '0;
				end else begin
					sum_q      <= sum_new;
					edge_cnt_q <= edge_new;
				end
			end else begin
				tick_cnt_q <= period;
			end
		end
	end

endmodule

@@ design/tach_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tach_queue: short job queue between front and back
// Two-entry queue so the tick counter keeps running while a speed is worked out.
// ----------------------------------------------------------------------------
module tach_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tach_pkg::tach_job_t push_job,
	input  logic                take,
	output logic                full,
	output tach_pkg::tach_qout_t qout
);
	import tach_pkg::*;

	tach_job_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_take;

	assign full      = count_q == QCNT_W'(QUEUE_DEPTH);
	assign qout.valid = count_q != '0;
	assign qout.job   = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_take   = take && qout.valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_take) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_take) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_take) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ design/tach_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tach_back: speed calculation and result register
// Forms 6000*rate*n and pulses*sum with registered multiplies, divides them
// one quotient bit a cycle and saturates the quotient into the result word.
// ----------------------------------------------------------------------------
module tach_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tach_pkg::tach_qout_t        qout,
	output logic                        take,
	input  logic [tach_pkg::RATE_W-1:0] tick_rate_hz,
	input  logic [tach_pkg::PPR_W-1:0]  pulses_per_rev,
	input  logic                        pop,
	output logic                        empty,
	output logic [tach_pkg::RPM_W-1:0]  rpm_hundredths,
	output logic [tach_pkg::SUM_W-1:0]  period_sum
);
	import tach_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL1 = 5'b00010,
		ST_MUL2 = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_DONE = 5'b10000
	} back_state_t;

	back_state_t          state_q;
	logic [EPA_W-1:0]     edges_q;
	logic [SUM_W-1:0]     sum_q;
	logic [R6_W-1:0]      rate6k_q;
	logic [DEN_W-1:0]     den_q;
	logic [NUM_W-1:0]     div_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 out_valid_q;
	logic [RPM_W-1:0]     rpm_q;
	logic [SUM_W-1:0]     psum_q;

	logic [PPR_W-1:0]     ppr_eff;
	logic [DEN_W:0]       rem_sh;
	logic                 ge;
	logic [DEN_W:0]       rem_sub;
	logic                 slot_free;

	assign ppr_eff   = (pulses_per_rev == '0) ? PPR_W'(1) : pulses_per_rev;
	assign take      = (state_q == ST_IDLE) && qout.valid;
	assign slot_free = !out_valid_q || pop;

	// one restoring division step
	assign rem_sh  = {rem_q, div_q[NUM_W-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	// calculation sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (qout.valid) begin
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_CNT_W'(NUM_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				edges_q <= qout.job.edges;
				sum_q   <= qout.job.sum;
			end
			ST_MUL1: begin
				rate6k_q <= R6_W'(tick_rate_hz) * R6_W'(RPM_SCALE);
				den_q    <= DEN_W'(ppr_eff) * DEN_W'(sum_q);
			end
			ST_MUL2: begin
				div_q <= NUM_W'(rate6k_q) * NUM_W'(edges_q);
				rem_q <= '0;
			end
			ST_DIV: begin
				rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
				div_q <= {div_q[NUM_W-2:0], ge};
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && slot_free) begin
			rpm_q  <= (div_q[NUM_W-1:RPM_W] != '0) ? RPM_MAX : div_q[RPM_W-1:0];
			psum_q <= sum_q;
		end
	end

	assign empty          = !out_valid_q;
	assign rpm_hundredths = rpm_q;
	assign period_sum     = psum_q;

endmodule

@@ design/averaging_tachometer_rpm_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// averaging_tachometer_rpm_top: period-averaging tachometer
// Counts timer ticks between encoder edges and reports averaged speed in
// hundredths of rpm together with the summed period.
// ----------------------------------------------------------------------------
// usage
//   input: one word per timer tick, taken when push is high and full is low;
//   capture_edge marks a tick carrying an encoder edge.
//   output: a word waits while empty is low and leaves when pop is high.
//   config: cfg_we with cfg_index writes tick rate (0), pulses per rev (1)
//   and edges per average (2) from cfg_data; write only while idle.
// timing
//   one tick word is accepted every cycle while full is low. a finished average
//   goes through a two-entry queue into the speed unit, which works on one job
//   at a time (two registered multiply steps, a 49-step restoring divider, the
//   result write). full rises when averages arrive faster than the speed unit
//   finishes them or results are not taken, and the queue fills. the result
//   register is written once the divider ends and the output slot is free.
// reset and stall
//   arst_n clears counters, sum, queue and the result valid flag and loads the
//   default configuration. when pop is held low the result register holds,
//   the speed unit waits, then the queue fills and full stalls the input.
// ----------------------------------------------------------------------------
module averaging_tachometer_rpm_top #(
	parameter int MAX_EDGES   = 256,
	parameter int PERIOD_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic                           capture_edge,
	output logic                           empty,
	input  logic                           pop,
	output logic [tach_pkg::RPM_W-1:0]     rpm_hundredths,
	output logic [tach_pkg::SUM_W-1:0]     period_sum,
	input  logic                           cfg_we,
	input  logic [tach_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tach_pkg::CFG_W-1:0]     cfg_data
);
	import tach_pkg::*;

	logic [RATE_W-1:0] tick_rate_q;
	logic [PPR_W-1:0]  ppr_q;
	logic [EPA_W-1:0]  epa_q;

	logic       tick;
	logic       job_push;
	tach_job_t  job;
	tach_qout_t qout;
	logic       take;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q <= TICK_RATE_RST;
			ppr_q       <= PPR_RST;
			epa_q       <= EPA_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TICK_RATE: tick_rate_q <= cfg_data[RATE_W-1:0];
				REG_PPR:       ppr_q       <= cfg_data[PPR_W-1:0];
				REG_EPA:       epa_q       <= cfg_data[EPA_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign tick = push && !full;

	// tick counting front
	tach_front #(
		.MAX_EDGES   (MAX_EDGES),
		.PERIOD_BITS (PERIOD_BITS)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.tick              (tick),
		.capture_edge      (capture_edge),
		.edges_per_average (epa_q),
		.job_push          (job_push),
		.job               (job)
	);

	// job queue
	tach_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (job),
		.take     (take),
		.full     (full),
		.qout     (qout)
	);

	// speed calculation back
	tach_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.qout           (qout),
		.take           (take),
		.tick_rate_hz   (tick_rate_q),
		.pulses_per_rev (ppr_q),
		.pop            (pop),
		.empty          (empty),
		.rpm_hundredths (rpm_hundredths),
		.period_sum     (period_sum)
	);

endmodule
